>>> rtl/dwc_pkg.sv
// ----------------------------------------------------------------------------
// dwc_pkg
// Shared types and constants for the deque with a wrapping cursor.
// ----------------------------------------------------------------------------
package dwc_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int ACTION_W   = 4;
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 5;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 8;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_HEAD = 4'd0,
        ACT_PUSH_TAIL = 4'd1,
        ACT_POP_HEAD  = 4'd2,
        ACT_POP_TAIL  = 4'd3,
        ACT_READ      = 4'd4,
        ACT_NEXT      = 4'd5,
        ACT_PREV      = 4'd6,
        ACT_JUMP_HEAD = 4'd7,
        ACT_JUMP_TAIL = 4'd8,
        ACT_COUNT     = 4'd9
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } t_dp_cmd;

endpackage

>>> rtl/dwc_ram.sv
// ----------------------------------------------------------------------------
// dwc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/dwc_ctrl.sv
// ----------------------------------------------------------------------------
// dwc_ctrl
// Sequencer: accept a word, update pointers, read the cursor entry, load the
// result register.
// ----------------------------------------------------------------------------
module dwc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output dwc_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_LOAD = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                // hold until the result register is free
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/dwc_dpath.sv
// ----------------------------------------------------------------------------
// dwc_dpath
// Pointer registers, entry count, ring store and result register.
// ----------------------------------------------------------------------------
module dwc_dpath #(
    parameter int DEPTH      = dwc_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dwc_pkg::DATA_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dwc_pkg::t_dp_cmd                  i_cmd,
    input  logic [dwc_pkg::ACTION_W-1:0]      i_action,
    input  logic signed [dwc_pkg::VALUE_W-1:0] i_value,
    output logic signed [dwc_pkg::VALUE_W-1:0] o_cursor_value,
    output logic [dwc_pkg::COUNT_W-1:0]       o_count,
    output logic [dwc_pkg::STATUS_W-1:0]      o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_CNT   = CW'(1);

    logic [dwc_pkg::ACTION_W-1:0] r_action;
    logic [dwc_pkg::VALUE_W-1:0]  r_value;
    logic [AW-1:0]                r_head, n_head;
    logic [AW-1:0]                r_tail, n_tail;
    logic [AW-1:0]                r_cursor, n_cursor;
    logic [CW-1:0]                r_count, n_count;
    dwc_pkg::t_status             r_status, n_status;

    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic [DATA_WIDTH-1:0]        w_wdata;
    logic [DATA_WIDTH-1:0]        w_rdata;
    logic [dwc_pkg::VALUE_W-1:0]  w_rd_word;
    logic [dwc_pkg::COUNT_W-1:0]  w_count_out;
    logic                         w_empty;
    logic                         w_full;

    logic [dwc_pkg::VALUE_W-1:0]  r_out_value;
    logic [dwc_pkg::COUNT_W-1:0]  r_out_count;
    logic [dwc_pkg::STATUS_W-1:0] r_out_status;

    function automatic logic [AW-1:0] slot_up(input logic [AW-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_down(input logic [AW-1:0] s);
        return (s == '0) ? LAST_SLOT : s - AW'(1);
    endfunction

    generate
        if (DATA_WIDTH <= dwc_pkg::VALUE_W) begin : g_narrow
            assign w_wdata = r_value[DATA_WIDTH-1:0];
            assign w_rd_word = dwc_pkg::VALUE_W'(w_rdata);
        end else begin : g_wide
            assign w_wdata = {{(DATA_WIDTH - dwc_pkg::VALUE_W){r_value[dwc_pkg::VALUE_W-1]}},
                              r_value};
            assign w_rd_word = w_rdata[dwc_pkg::VALUE_W-1:0];
        end
        if (CW >= dwc_pkg::COUNT_W) begin : g_cnt_trunc
            assign w_count_out = r_count[dwc_pkg::COUNT_W-1:0];
        end else begin : g_cnt_ext
            assign w_count_out = dwc_pkg::COUNT_W'(r_count);
        end
    endgenerate

    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == FULL_CNT);

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_cursor = r_cursor;
        n_count  = r_count;
        n_status = dwc_pkg::ST_OK;
        w_we     = 1'b0;
        w_waddr  = r_head;
        case (dwc_pkg::t_action'(r_action))
            dwc_pkg::ACT_PUSH_HEAD, dwc_pkg::ACT_PUSH_TAIL: begin
                if (w_full) begin
                    n_status = dwc_pkg::ST_FULL;
                end else if (w_empty) begin
                    w_we     = 1'b1;
                    n_tail   = r_head;
                    n_cursor = r_head;
                    n_count  = ONE_CNT;
                end else if (r_action == dwc_pkg::ACT_PUSH_HEAD) begin
                    w_we    = 1'b1;
                    n_head  = slot_down(r_head);
                    w_waddr = n_head;
                    n_count = r_count + ONE_CNT;
                end else begin
                    w_we    = 1'b1;
                    n_tail  = slot_up(r_tail);
                    w_waddr = n_tail;
                    n_count = r_count + ONE_CNT;
                end
            end
            dwc_pkg::ACT_POP_HEAD, dwc_pkg::ACT_POP_TAIL: begin
                if (w_empty) begin
                    n_status = dwc_pkg::ST_EMPTY;
                end else if (r_count == ONE_CNT) begin
                    n_count  = '0;
                    n_tail   = r_head;
                    n_cursor = r_head;
                end else if (r_action == dwc_pkg::ACT_POP_HEAD) begin
                    n_head  = slot_up(r_head);
                    n_count = r_count - ONE_CNT;
                    if (r_cursor == r_head) begin
                        n_cursor = n_head;
                    end
                end else begin
                    n_tail  = slot_down(r_tail);
                    n_count = r_count - ONE_CNT;
                    if (r_cursor == r_tail) begin
                        n_cursor = n_tail;
                    end
                end
            end
            dwc_pkg::ACT_READ: begin
                if (w_empty) begin
                    n_status = dwc_pkg::ST_EMPTY;
                end
            end
            dwc_pkg::ACT_NEXT: begin
                if (w_empty) begin
                    n_status = dwc_pkg::ST_EMPTY;
                end else begin
                    n_cursor = (r_cursor == r_tail) ? r_head : slot_up(r_cursor);
                end
            end
            dwc_pkg::ACT_PREV: begin
                if (w_empty) begin
                    n_status = dwc_pkg::ST_EMPTY;
                end else begin
                    n_cursor = (r_cursor == r_head) ? r_tail : slot_down(r_cursor);
                end
            end
            dwc_pkg::ACT_JUMP_HEAD: begin
                if (w_empty) begin
                    n_status = dwc_pkg::ST_EMPTY;
                end else begin
                    n_cursor = r_head;
                end
            end
            dwc_pkg::ACT_JUMP_TAIL: begin
                if (w_empty) begin
                    n_status = dwc_pkg::ST_EMPTY;
                end else begin
                    n_cursor = r_tail;
                end
            end
            default: begin
            end
        endcase
    end

    dwc_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we && i_cmd.exec),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_cursor),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_cursor <= '0;
            r_count  <= '0;
        end else if (i_cmd.exec) begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_cursor <= n_cursor;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_action <= i_action;
            r_value  <= i_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
        if (i_cmd.load_out) begin
            r_out_value  <= w_empty ? '0 : w_rd_word;
            r_out_count  <= w_count_out;
            r_out_status <= r_status;
        end
    end

    assign o_cursor_value = r_out_value;
    assign o_count        = r_out_count;
    assign o_status       = r_out_status;

endmodule

>>> rtl/deque_with_wrapping_cursor.sv
// ----------------------------------------------------------------------------
// deque_with_wrapping_cursor
// Double-ended queue of signed words in a ring store, with a wrapping cursor.
// ----------------------------------------------------------------------------
//  port group  | dir | contents
//  s_axis      | in  | tuser: action; tdata: value
//  m_axis      | out | tdata: cursor_value, count, status
//
//  An item goes from accept to result through pointer update and store
//  write, then the store's registered read of the cursor entry, then the
//  result register load. The next item is accepted only after the result
//  register has been loaded for the one before it.
//  Reset clears pointers, count and result valid; store contents stay unknown.
//  A result waiting on m_axis does not block the next accept; a second result
//  holds in the sequencer until the first is taken.
// ----------------------------------------------------------------------------
module deque_with_wrapping_cursor #(
    parameter int DEPTH      = dwc_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dwc_pkg::DATA_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [31:0] value
    input  logic [dwc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [3:0] action, [7:4] zero
    input  logic [dwc_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] cursor_value, [36:32] count, [38:37] status, [39] zero
    output logic [dwc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    dwc_pkg::t_dp_cmd                   w_cmd;
    logic signed [dwc_pkg::VALUE_W-1:0] w_cursor_value;
    logic [dwc_pkg::COUNT_W-1:0]        w_count;
    logic [dwc_pkg::STATUS_W-1:0]       w_status;

    dwc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    dwc_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_action       (s_axis_tuser[dwc_pkg::ACTION_W-1:0]),
        .i_value        (s_axis_tdata[dwc_pkg::VALUE_W-1:0]),
        .o_cursor_value (w_cursor_value),
        .o_count        (w_count),
        .o_status       (w_status)
    );

    assign m_axis_tdata = {1'b0, w_status, w_count, w_cursor_value};

endmodule

>>> tb/deque_with_wrapping_cursor_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deque_with_wrapping_cursor_test
// Self-checking bench for the deque with a wrapping cursor. Actions go in on
// the slave stream and are mirrored by a local deque model. Each result word
// on the master stream is compared to the oldest predicted one. Directed
// checks cover the empty and the full queue, cursor wrap and pops under the
// cursor. Random runs fill and drain the queue with gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module deque_with_wrapping_cursor_test;

    localparam int DEPTH       = dwc_pkg::DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_RUNS = 38;
    localparam int RUN_LENGTH  = 50;

    typedef struct packed {
        logic [31:0]                 cursor_value;
        logic [dwc_pkg::COUNT_W-1:0] count;
        dwc_pkg::t_status            status;
    } t_deque_result;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [dwc_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic [dwc_pkg::IN_USER_W-1:0]  s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [dwc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    logic [31:0]    deque_store [DEPTH];
    int unsigned    head_slot;
    int unsigned    tail_slot;
    int unsigned    cursor_slot;
    int unsigned    entry_count;

    t_deque_result  pending_results [$];
    int             mismatch_count;
    int             cycle_count;
    bit             idle_on;
    int             rx_hold_req;

    deque_with_wrapping_cursor uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic int unsigned slot_fwd(int unsigned s);
        return (s + 1 >= DEPTH) ? 0 : s + 1;
    endfunction

    function automatic int unsigned slot_back(int unsigned s);
        return (s == 0) ? DEPTH - 1 : s - 1;
    endfunction

    function automatic t_deque_result apply_deque_action(
        logic [dwc_pkg::ACTION_W-1:0] action, logic [31:0] value);
        t_deque_result    res;
        dwc_pkg::t_status st;
        bit               empty;
        bit               at_end;
        st    = dwc_pkg::ST_OK;
        empty = (entry_count == 0);
        case (action)
            dwc_pkg::ACT_PUSH_HEAD, dwc_pkg::ACT_PUSH_TAIL: begin
                if (entry_count >= DEPTH) begin
                    st = dwc_pkg::ST_FULL;
                end else if (empty) begin
                    deque_store[head_slot] = value;
                    tail_slot   = head_slot;
                    cursor_slot = head_slot;
                    entry_count = 1;
                end else if (action == dwc_pkg::ACT_PUSH_HEAD) begin
                    head_slot = slot_back(head_slot);
                    deque_store[head_slot] = value;
                    entry_count++;
                end else begin
                    tail_slot = slot_fwd(tail_slot);
                    deque_store[tail_slot] = value;
                    entry_count++;
                end
            end
            dwc_pkg::ACT_POP_HEAD, dwc_pkg::ACT_POP_TAIL: begin
                if (empty) begin
                    st = dwc_pkg::ST_EMPTY;
                end else if (entry_count == 1) begin
                    entry_count = 0;
                    tail_slot   = head_slot;
                    cursor_slot = head_slot;
                end else if (action == dwc_pkg::ACT_POP_HEAD) begin
                    at_end    = (cursor_slot == head_slot);
                    head_slot = slot_fwd(head_slot);
                    if (at_end) cursor_slot = head_slot;
                    entry_count--;
                end else begin
                    at_end    = (cursor_slot == tail_slot);
                    tail_slot = slot_back(tail_slot);
                    if (at_end) cursor_slot = tail_slot;
                    entry_count--;
                end
            end
            dwc_pkg::ACT_READ: begin
                if (empty) st = dwc_pkg::ST_EMPTY;
            end
            dwc_pkg::ACT_NEXT: begin
                if (empty) st = dwc_pkg::ST_EMPTY;
                else cursor_slot = (cursor_slot == tail_slot) ? head_slot
                                                              : slot_fwd(cursor_slot);
            end
            dwc_pkg::ACT_PREV: begin
                if (empty) st = dwc_pkg::ST_EMPTY;
                else cursor_slot = (cursor_slot == head_slot) ? tail_slot
                                                              : slot_back(cursor_slot);
            end
            dwc_pkg::ACT_JUMP_HEAD: begin
                if (empty) st = dwc_pkg::ST_EMPTY;
                else cursor_slot = head_slot;
            end
            dwc_pkg::ACT_JUMP_TAIL: begin
                if (empty) st = dwc_pkg::ST_EMPTY;
                else cursor_slot = tail_slot;
            end
            default: ;
        endcase
        res.cursor_value = (entry_count == 0) ? 32'd0 : deque_store[cursor_slot];
        res.count        = entry_count[dwc_pkg::COUNT_W-1:0];
        res.status       = st;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (!idle_on || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 3) return 32'h7FFF_FFFF;
        if (r < 6) return 32'h8000_0000;
        if (r < 8) return 32'h0000_0000;
        if (r < 10) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // bias: 0 grow, 1 shrink, 2 balanced
    function automatic logic [dwc_pkg::ACTION_W-1:0] pick_action(int bias);
        int r;
        int push_lim;
        int pop_lim;
        r = $urandom_range(99);
        push_lim = (bias == 0) ? 50 : (bias == 1) ? 15 : 30;
        pop_lim  = push_lim + ((bias == 0) ? 12 : (bias == 1) ? 45 : 30);
        if (r < push_lim)
            return $urandom_range(0, 1) ? dwc_pkg::ACT_PUSH_TAIL : dwc_pkg::ACT_PUSH_HEAD;
        if (r < pop_lim)
            return $urandom_range(0, 1) ? dwc_pkg::ACT_POP_TAIL : dwc_pkg::ACT_POP_HEAD;
        if (r < 96)
            return dwc_pkg::ACTION_W'($urandom_range(dwc_pkg::ACT_READ, dwc_pkg::ACT_COUNT));
        return dwc_pkg::ACTION_W'($urandom_range(10, 15));
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, field, got, want);
        mismatch_count++;
    endtask

    task automatic send_word(logic [dwc_pkg::ACTION_W-1:0] action, logic [31:0] value);
        int gap;
        gap = pick_gap();
        for (int k = 0; k < gap; k++) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= {{(dwc_pkg::IN_USER_W-dwc_pkg::ACTION_W){1'b0}}, action};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(apply_deque_action(action, value));
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_deque_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata[31:0], 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== want.cursor_value)
                    report_mismatch("cursor_value", m_axis_tdata[31:0], want.cursor_value);
                if (m_axis_tdata[36:32] !== want.count)
                    report_mismatch("count", 32'(m_axis_tdata[36:32]), 32'(want.count));
                if (m_axis_tdata[38:37] !== want.status)
                    report_mismatch("status", 32'(m_axis_tdata[38:37]), 32'(want.status));
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin
        int stall_left;
        int hold_left;
        stall_left    = 0;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                stall_left = ($urandom_range(99) < 25) ? pick_gap() : 0;
                if (stall_left > 0) begin
                    stall_left--;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    task automatic test_empty_queue();
        send_word(dwc_pkg::ACT_POP_HEAD, 32'h1234_5678);
        send_word(dwc_pkg::ACT_POP_TAIL, 32'hFFFF_FFFF);
        send_word(dwc_pkg::ACT_READ, 32'h0);
        send_word(dwc_pkg::ACT_NEXT, 32'h0);
        send_word(dwc_pkg::ACT_PREV, 32'h0);
        send_word(dwc_pkg::ACT_JUMP_HEAD, 32'h0);
        send_word(dwc_pkg::ACT_JUMP_TAIL, 32'h0);
        send_word(dwc_pkg::ACT_COUNT, 32'h0);
        send_word(4'hF, 32'hFFFF_FFFF);
    endtask

    task automatic test_cursor_and_pops();
        send_word(dwc_pkg::ACT_PUSH_TAIL, 32'h7FFF_FFFF);
        send_word(dwc_pkg::ACT_PUSH_HEAD, 32'h8000_0000);
        send_word(dwc_pkg::ACT_NEXT, 32'h0);
        send_word(dwc_pkg::ACT_PREV, 32'h0);
        send_word(dwc_pkg::ACT_JUMP_HEAD, 32'h0);
        send_word(dwc_pkg::ACT_POP_HEAD, 32'h0);
        send_word(dwc_pkg::ACT_PUSH_HEAD, 32'h0000_0000);
        send_word(dwc_pkg::ACT_PUSH_TAIL, 32'hFFFF_FFFF);
        send_word(dwc_pkg::ACT_JUMP_TAIL, 32'h0);
        send_word(dwc_pkg::ACT_POP_TAIL, 32'h0);
        send_word(dwc_pkg::ACT_READ, 32'h0);
        send_word(dwc_pkg::ACT_COUNT, 32'h0);
        send_word(dwc_pkg::ACT_POP_HEAD, 32'h0);
        send_word(dwc_pkg::ACT_POP_TAIL, 32'h0);
        send_word(dwc_pkg::ACT_POP_TAIL, 32'h0);
    endtask

    task automatic test_full_queue();
        for (int k = 0; k < DEPTH; k++)
            send_word($urandom_range(0, 1) ? dwc_pkg::ACT_PUSH_TAIL : dwc_pkg::ACT_PUSH_HEAD,
                      pick_value());
        send_word(dwc_pkg::ACT_PUSH_HEAD, pick_value());
        send_word(dwc_pkg::ACT_PUSH_TAIL, pick_value());
        send_word(dwc_pkg::ACT_NEXT, $urandom);
    endtask

    task automatic test_input_stall();
        idle_on     = 1'b0;
        rx_hold_req = 400;
        for (int k = 0; k < 12; k++)
            send_word(pick_action(2), pick_value());
        idle_on = 1'b1;
    endtask

    task automatic test_random_mix();
        int bias;
        for (int run = 0; run < RANDOM_RUNS; run++) begin
            bias    = $urandom_range(0, 2);
            idle_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < RUN_LENGTH; k++)
                send_word(pick_action(bias), pick_value());
        end
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        idle_on        = 1'b1;
        rx_hold_req    = 0;
        head_slot      = 0;
        tail_slot      = 0;
        cursor_slot    = 0;
        entry_count    = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_queue();
        test_cursor_and_pops();
        test_full_queue();
        test_input_stall();
        test_random_mix();

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
